>>> rtl/core/dcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants for the drift compensated clock
// Default ratio format, tick scale, register indexes, item codes and the
// request/response bundles of the iterative ratio divider.
// ----------------------------------------------------------------------------
package dcc_pkg;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF    = 30;
  localparam int TICKS_PER_MS_DEF = 10000;

  // Width of the configuration register index
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADJUSTMENT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MS = 8'd2;

  // Item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_OFFSET = 1'b1;

  // Divider request: start pulse with numerator and denominator
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  // Divider response: done pulse, ratio below 2.0, truncated ratio
  typedef struct packed {
    logic        done;
    logic        ok;
    logic [31:0] q;
  } div_res_t;

endpackage

>>> rtl/core/dcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_if: channel interfaces of the drift compensated clock
// Sample channel, result channel and configuration write channel, each a
// valid/ready handshake with a source and a sink side.
// ----------------------------------------------------------------------------

// Input items
interface dcc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] sys_ms;
  logic        hw_valid;
  logic [63:0] hw_clock;
  logic [63:0] hw_counter;
  logic [31:0] offset_ms;

  modport source (output valid, op, sys_ms, hw_valid, hw_clock, hw_counter, offset_ms,
                  input ready);
  modport sink (input valid, op, sys_ms, hw_valid, hw_clock, hw_counter, offset_ms,
                output ready);
endinterface

// Result items
interface dcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] private_time;
  logic [31:0]        drift_ratio;

  modport source (output valid, private_time, drift_ratio, input ready);
  modport sink (input valid, private_time, drift_ratio, output ready);
endinterface

// Configuration writes
interface dcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/drift_compensated_clock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drift_compensated_clock_top: 100 ns private time with drift compensation
// Sequencer around one shared 32x32 multiplier and an iterative divider.
// ----------------------------------------------------------------------------
// One item is taken at a time; sample.ready is high only while the sequencer
// is idle. A sample item with a valid hardware reading that needs a new ratio
// (Q2.30 at the default FRAC_BITS) waits on the divider, which produces one
// quotient bit per cycle; without a ratio update its work is set by the three
// scaling products, each split into two 32x32 partial products on the shared
// multiplier. The very first item after reset also loads the start time. The
// result sits in an output register, so the next item is accepted while it
// waits; an item only stalls in its final state while the previous result is
// still waiting. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module drift_compensated_clock_top
  import dcc_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  dcc_in_if.sink   sample,
  dcc_out_if.source result,
  dcc_cfg_if.sink  cfg
);

  localparam logic [31:0] TICKS = 32'(TICKS_PER_MS);
  localparam logic [31:0] Q_ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [36:0] LO_LIM = 37'(19 * (64'd1 << FRAC_BITS));
  localparam logic [36:0] HI_LIM = 37'(21 * (64'd1 << FRAC_BITS));
  localparam logic [1:0]  LAST_STEP = 2'd2;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_INIT   = 14'b00000000000010,
    S_INITWB = 14'b00000000000100,
    S_OFS    = 14'b00000000001000,
    S_OFSWB  = 14'b00000000010000,
    S_TRACK  = 14'b00000000100000,
    S_DIV    = 14'b00000001000000,
    S_DELTA  = 14'b00000010000000,
    S_DWB    = 14'b00000100000000,
    S_MLO    = 14'b00001000000000,
    S_MHI    = 14'b00010000000000,
    S_MCOMB  = 14'b00100000000000,
    S_ACC    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  // Ratio lies within 0.95 .. 1.05 (exact compare via q * 20)
  function automatic logic in_band(input logic [31:0] q);
    logic [36:0] q20;
    q20 = (37'(q) << 4) + (37'(q) << 2);
    return (q20 >= LO_LIM) && (q20 <= HI_LIM);
  endfunction

  state_t state;

  // Configuration registers
  logic [31:0] adjustment;
  logic [31:0] bias;
  logic [31:0] initial_ms;

  // Architectural state
  logic        started;
  logic [63:0] acc;
  logic [31:0] prev_sys_ms;
  logic [63:0] start_clock;
  logic [63:0] start_counter;
  logic [63:0] prev_clock;
  logic [31:0] drift;

  // Latched item
  logic        lat_op;
  logic [31:0] lat_sys_ms;
  logic        lat_hw_valid;
  logic [63:0] lat_clock;
  logic [63:0] lat_counter;
  logic [31:0] lat_offset;

  // Shared multiplier and scaling datapath
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] lo_prod;
  logic [63:0] dval;
  logic [1:0]  step;
  logic [31:0] step_factor;
  logic [95:0] pfull;
  logic        psat;
  logic [63:0] pres;

  // Hardware tracking
  logic [63:0] clk_base;
  logic [63:0] cnt_base;
  logic [63:0] clk_diff;
  logic [63:0] cnt_diff;
  logic        backwards;

  div_req_t div_req;
  div_res_t div_res;

  // Output register
  logic               out_valid;
  logic signed [63:0] out_time;
  logic [31:0]        out_drift;

  logic in_xfer;
  logic out_free;

  assign in_xfer  = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign result.valid        = out_valid;
  assign result.private_time = out_time;
  assign result.drift_ratio  = out_drift;

  // Scaling factor for the current product
  always_comb begin
    unique case (step)
      2'd0:    step_factor = adjustment;
      2'd1:    step_factor = bias;
      default: step_factor = drift;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_INIT: begin
        mul_a = initial_ms;
        mul_b = TICKS;
      end
      S_OFS: begin
        mul_a = lat_offset;
        mul_b = TICKS;
      end
      S_DELTA: begin
        mul_a = lat_sys_ms - prev_sys_ms;
        mul_b = TICKS;
      end
      S_MLO: begin
        mul_a = dval[31:0];
        mul_b = step_factor;
      end
      S_MHI: begin
        mul_a = dval[63:32];
        mul_b = step_factor;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // Combine partial products, shift out the fraction, saturate
  assign pfull = {prod, 32'b0} + {32'b0, lo_prod};
  assign psat  = |(pfull >> (64 + FRAC_BITS));
  assign pres  = pfull[FRAC_BITS +: 64];

  // Start values and differences of a hardware reading
  assign clk_base  = (start_clock == '0) ? lat_clock : start_clock;
  assign cnt_base  = (start_counter == '0) ? lat_counter : start_counter;
  assign clk_diff  = lat_clock - clk_base;
  assign cnt_diff  = lat_counter - cnt_base;
  assign backwards = prev_clock > lat_clock;

  assign div_req.start = (state == S_TRACK) && lat_hw_valid && !backwards
                         && (clk_diff != '0) && (cnt_diff != '0);
  assign div_req.num   = clk_diff;
  assign div_req.den   = cnt_diff;

  dcc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .res(div_res)
  );

  // Item latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lat_op       <= sample.op;
      lat_sys_ms   <= sample.sys_ms;
      lat_hw_valid <= sample.hw_valid;
      lat_clock    <= sample.hw_clock;
      lat_counter  <= sample.hw_counter;
      lat_offset   <= sample.offset_ms;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      adjustment <= Q_ONE;
      bias       <= Q_ONE;
      initial_ms <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_ADJUSTMENT: adjustment <= cfg.data;
        REG_BIAS:       bias       <= cfg.data;
        REG_INITIAL_MS: initial_ms <= cfg.data;
        default: ;
      endcase
    end
  end

  // Result valid: set when a result is loaded, cleared on its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      started       <= 1'b0;
      acc           <= '0;
      prev_sys_ms   <= '0;
      start_clock   <= '0;
      start_counter <= '0;
      prev_clock    <= '0;
      drift         <= Q_ONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (!started)                     state <= S_INIT;
            else if (sample.op == OP_OFFSET)  state <= S_OFS;
            else                              state <= S_TRACK;
          end
        end
        S_INIT: begin
          prev_sys_ms <= initial_ms;
          started     <= 1'b1;
          state       <= S_INITWB;
        end
        S_INITWB: begin
          acc   <= prod;
          state <= (lat_op == OP_OFFSET) ? S_OFS : S_TRACK;
        end
        S_OFS: state <= S_OFSWB;
        S_OFSWB: begin
          acc   <= acc + prod;
          state <= S_DONE;
        end
        S_TRACK: begin
          state <= div_req.start ? S_DIV : S_DELTA;
          if (lat_hw_valid) begin
            if (backwards) begin
              start_clock   <= lat_clock;
              start_counter <= lat_counter;
              prev_clock    <= lat_clock;
            end else begin
              start_clock   <= clk_base;
              start_counter <= cnt_base;
              if (!div_req.start) begin
                if (!in_band(drift)) drift <= Q_ONE;
                prev_clock <= lat_clock;
              end
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            drift      <= (div_res.ok && in_band(div_res.q)) ? div_res.q : Q_ONE;
            prev_clock <= lat_clock;
            state      <= S_DELTA;
          end
        end
        S_DELTA: begin
          prev_sys_ms <= lat_sys_ms;
          step        <= '0;
          state       <= S_DWB;
        end
        S_DWB: begin
          dval  <= prod;
          state <= S_MLO;
        end
        S_MLO: state <= S_MHI;
        S_MHI: begin
          lo_prod <= prod;
          state   <= S_MCOMB;
        end
        S_MCOMB: begin
          dval  <= psat ? '1 : pres;
          step  <= step + 2'd1;
          state <= (step == LAST_STEP) ? S_ACC : S_MLO;
        end
        S_ACC: begin
          acc   <= acc + dval;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_time  <= $signed(acc);
            out_drift <= drift;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted item leaves the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !sample.ready)
    else $error("sample accepted while previous item still in work");

  // Drift multiplier never leaves the 0.95 .. 1.05 band
  a_drift_band: assert property (@(posedge clk) disable iff (rst)
    in_band(drift))
    else $error("drift ratio outside band");

  // A result only follows the start load
  a_result_started: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> started)
    else $error("result before start load");

  // Divider completes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider done outside wait state");
`endif

endmodule

>>> rtl/core/dcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_div: iterative fixed-point ratio divider
// Computes floor(num * 2^FRAC_BITS / den) one quotient bit per cycle with a
// single 65-bit compare/subtract. Flags ratios of 2.0 or more as not ok.
// ----------------------------------------------------------------------------
module dcc_div
  import dcc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_res_t res
);

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAC_BITS - 1);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_PRE  = 4'b0010,
    D_ITER = 4'b0100,
    D_FIN  = 4'b1000
  } dstate_t;

  dstate_t              dstate;
  logic [63:0]          num;
  logic [63:0]          den;
  logic [63:0]          rem;
  logic                 ip;
  logic                 ok;
  logic [FRAC_BITS-1:0] frac;
  logic [CNT_W-1:0]     cnt;

  logic [64:0] rem_sh;
  logic        rem_ge;
  logic [64:0] rem_diff;
  logic        over;
  logic        int_one;

  // Shared compare/subtract
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};

  // Integer part check: ratio of 2.0 or more fails
  assign over    = {1'b0, num} >= {den, 1'b0};
  assign int_one = num >= den;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
    end else begin
      unique case (dstate)
        D_IDLE: if (req.start) dstate <= D_PRE;
        D_PRE:  dstate <= over ? D_FIN : D_ITER;
        D_ITER: if (cnt == LAST_CNT) dstate <= D_FIN;
        D_FIN:  dstate <= D_IDLE;
        default: dstate <= D_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (dstate)
      D_IDLE: begin
        num <= req.num;
        den <= req.den;
        cnt <= '0;
      end
      D_PRE: begin
        ok  <= !over;
        ip  <= int_one;
        rem <= int_one ? (num - den) : num;
      end
      D_ITER: begin
        cnt  <= cnt + CNT_W'(1);
        frac <= {frac[FRAC_BITS-2:0], rem_ge};
        if (rem_ge) rem <= rem_diff[63:0];
        else        rem <= rem_sh[63:0];
      end
      D_FIN: ;
      default: ;
    endcase
  end

  assign res.done = (dstate == D_FIN);
  assign res.ok   = ok;
  assign res.q    = 32'({ip, frac});

endmodule

>>> tb/tb_drift_compensated_clock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drift_compensated_clock_top: self-checking bench for the drift clock
// Items go from a queue to a valid/ready driver. A cycle-free model
// of private time and drift predicts one result per item. A monitor compares
// each result transfer with the oldest prediction. Register settings change
// between phases, and both sides stall in three idle patterns.
// ----------------------------------------------------------------------------
module tb_drift_compensated_clock_top;
  import dcc_pkg::*;

  localparam int          FB       = FRAC_BITS_DEF;
  localparam logic [63:0] TICKS    = 64'(TICKS_PER_MS_DEF);
  localparam logic [63:0] Q_ONE    = 64'd1 << FB;
  localparam logic [63:0] DRIFT_LO = 64'd19 * Q_ONE;  // 0.95, scaled by 20
  localparam logic [63:0] DRIFT_HI = 64'd21 * Q_ONE;  // 1.05, scaled by 20
  localparam int          RANDOM_PER_PHASE = 140;
  localparam int          SWAP_IDLE_AT     = 290;
  localparam int          NO_IDLE_AT       = 580;

  typedef struct packed {
    logic        op;
    logic [31:0] sys_ms;
    logic        hw_valid;
    logic [63:0] hw_clock;
    logic [63:0] hw_counter;
    logic [31:0] offset_ms;
  } dcc_item_t;

  typedef struct packed {
    logic [63:0] private_time;
    logic [31:0] drift_ratio;
  } clock_reading_t;

  logic clk = 1'b0;
  logic rst;

  dcc_in_if  sample_if ();
  dcc_out_if result_if ();
  dcc_cfg_if cfg_if ();

  drift_compensated_clock_top u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and expectation stores
  dcc_item_t      pending_items[$];
  clock_reading_t expected_times[$];
  dcc_item_t      cur_item;

  int unsigned n_pushed  = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors  = 0;
  int unsigned n_writes  = 0;
  int unsigned n_offsets = 0;
  int unsigned n_ratios  = 0;
  int unsigned n_restarts = 0;

  // Model of the block: registers and state
  logic [31:0] mdl_adj       = Q_ONE[31:0];
  logic [31:0] mdl_bias      = Q_ONE[31:0];
  logic [31:0] mdl_init_ms   = '0;
  logic        mdl_started   = 1'b0;
  logic [63:0] mdl_time      = '0;
  logic [31:0] mdl_last_ms   = '0;
  logic [63:0] mdl_start_clk = '0;
  logic [63:0] mdl_start_cnt = '0;
  logic [63:0] mdl_last_clk  = '0;
  logic [31:0] mdl_drift     = Q_ONE[31:0];

  // Random sequence generator state
  logic [31:0] gen_ms;
  logic [63:0] gen_last_clk;
  logic [63:0] sess_clk, sess_cnt, sess_run, sess_rate;

  // (v * m) >> FB, saturating at 64 bits
  function automatic logic [63:0] scale_q(logic [63:0] v, logic [31:0] m);
    logic [127:0] p;
    p = {64'd0, v} * {96'd0, m};
    if ((p >> (64 + FB)) != 0) return '1;
    return p[FB+63:FB];
  endfunction

  // Apply one item to the model and return the reading it yields
  function automatic clock_reading_t clock_model_step(dcc_item_t it);
    logic [31:0]    dms;
    logic [63:0]    ticks, cd, qd, q20;
    logic [127:0]   quo;
    clock_reading_t r;
    if (!mdl_started) begin
      mdl_time    = 64'(mdl_init_ms) * TICKS;
      mdl_last_ms = mdl_init_ms;
      mdl_started = 1'b1;
    end
    if (it.op == OP_OFFSET) begin
      mdl_time += 64'(it.offset_ms) * TICKS;
      n_offsets++;
    end else begin
      if (it.hw_valid) begin
        if (mdl_start_cnt == 0) mdl_start_cnt = it.hw_counter;
        if (mdl_start_clk == 0) mdl_start_clk = it.hw_clock;
        if (mdl_last_clk > it.hw_clock) begin
          // clock went backwards: restart from this reading, keep drift
          mdl_start_clk = it.hw_clock;
          mdl_last_clk  = it.hw_clock;
          mdl_start_cnt = it.hw_counter;
          n_restarts++;
        end else begin
          cd = it.hw_clock - mdl_start_clk;
          qd = it.hw_counter - mdl_start_cnt;
          if (cd != 0 && qd != 0) begin
            quo = ({64'd0, cd} << FB) / {64'd0, qd};
            q20 = 64'(quo[31:0]) * 64'd20;
            if (quo < (128'd2 << FB) && q20 >= DRIFT_LO && q20 <= DRIFT_HI) begin
              mdl_drift = quo[31:0];
              n_ratios++;
            end else begin
              mdl_drift = Q_ONE[31:0];
            end
          end
          mdl_last_clk = it.hw_clock;
        end
      end
      dms         = it.sys_ms - mdl_last_ms;
      mdl_last_ms = it.sys_ms;
      ticks       = 64'(dms) * TICKS;
      mdl_time   += scale_q(scale_q(scale_q(ticks, mdl_adj), mdl_bias), mdl_drift);
    end
    r.private_time = mdl_time;
    r.drift_ratio  = mdl_drift;
    return r;
  endfunction

  // Idle percentages for the three stall patterns
  function automatic int unsigned send_gap_pct();
    if (n_sent < SWAP_IDLE_AT) return 18;
    if (n_sent < NO_IDLE_AT) return 78;
    return 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    if (n_sent < SWAP_IDLE_AT) return 78;
    if (n_sent < NO_IDLE_AT) return 18;
    return 0;
  endfunction

  // Sample channel driver
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        expected_times.push_back(clock_model_step(cur_item));
        n_sent++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
          cur_item             = pending_items.pop_front();
          sample_if.valid      <= 1'b1;
          sample_if.op         <= cur_item.op;
          sample_if.sys_ms     <= cur_item.sys_ms;
          sample_if.hw_valid   <= cur_item.hw_valid;
          sample_if.hw_clock   <= cur_item.hw_clock;
          sample_if.hw_counter <= cur_item.hw_counter;
          sample_if.offset_ms  <= cur_item.offset_ms;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin : result_check
    clock_reading_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        n_checked++;
        if (expected_times.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, private_time %h drift_ratio %h", $time,
                   result_if.private_time, result_if.drift_ratio);
        end else begin
          want = expected_times.pop_front();
          if (result_if.private_time !== want.private_time) begin
            n_errors++;
            $display("%0t: private_time expected %h actual %h", $time,
                     want.private_time, result_if.private_time);
          end
          if (result_if.drift_ratio !== want.drift_ratio) begin
            n_errors++;
            $display("%0t: drift_ratio expected %h actual %h", $time,
                     want.drift_ratio, result_if.drift_ratio);
          end
        end
      end
      result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  task automatic push_item(input logic op, input logic [31:0] ms, input logic hv,
                           input logic [63:0] hclk, input logic [63:0] hcnt,
                           input logic [31:0] off);
    dcc_item_t it;
    it = '{op: op, sys_ms: ms, hw_valid: hv, hw_clock: hclk, hw_counter: hcnt,
           offset_ms: off};
    pending_items.push_back(it);
    n_pushed++;
  endtask

  // Random item: mostly steady hardware sessions, some offsets and noise
  function automatic dcc_item_t next_random_item();
    dcc_item_t it;
    it.op         = OP_SAMPLE;
    it.sys_ms     = $urandom;
    it.hw_valid   = 1'($urandom_range(0, 1));
    it.hw_clock   = {$urandom, $urandom};
    it.hw_counter = {$urandom, $urandom};
    it.offset_ms  = $urandom;
    if ($urandom_range(0, 99) < 10) begin
      it.op = OP_OFFSET;
      if ($urandom_range(0, 3) != 0) it.offset_ms = $urandom_range(0, 5000);
    end else begin
      if ($urandom_range(0, 19) == 0) gen_ms = $urandom;
      else gen_ms += $urandom_range(0, 3000);
      it.sys_ms   = gen_ms;
      it.hw_valid = ($urandom_range(0, 99) < 85);
      if (it.hw_valid && $urandom_range(0, 19) != 0) begin
        if ($urandom_range(0, 15) == 0) begin
          // new session, half the time stepping the clock back to force a restart
          sess_clk  = $urandom_range(0, 1) ? (gen_last_clk >> 1) : {$urandom, $urandom};
          sess_cnt  = {$urandom, $urandom};
          sess_run  = '0;
          sess_rate = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(800, 1300))
                                                  : 64'($urandom_range(940, 1060));
        end
        sess_run     += 64'($urandom_range(1, 200000));
        it.hw_clock   = sess_clk + sess_run * sess_rate / 1000;
        it.hw_counter = sess_cnt + sess_run;
      end
      if (it.hw_valid) gen_last_clk = it.hw_clock;
    end
    return it;
  endfunction

  // Called at a clock edge; returns at the edge of the transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_ADJUSTMENT: mdl_adj = val;
      REG_BIAS:       mdl_bias = val;
      REG_INITIAL_MS: mdl_init_ms = val;
      default: ;
    endcase
    n_writes++;
  endtask

  // Every item yields one result, so idle means all results are back
  task automatic wait_idle();
    do @(posedge clk); while (n_checked != n_pushed);
  endtask

  task automatic start_phase(input logic [31:0] adj, input logic [31:0] bias,
                             input logic [31:0] init_ms);
    wait_idle();
    write_reg(REG_ADJUSTMENT, adj);
    write_reg(REG_BIAS, bias);
    write_reg(REG_INITIAL_MS, init_ms);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] adj_set[6];
    logic [31:0] bias_set[6];
    rst                  = 1'b1;
    sample_if.valid      = 1'b0;
    sample_if.op         = OP_SAMPLE;
    sample_if.sys_ms     = '0;
    sample_if.hw_valid   = 1'b0;
    sample_if.hw_clock   = '0;
    sample_if.hw_counter = '0;
    sample_if.offset_ms  = '0;
    result_if.ready      = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: start load from the top initial time, ratio edges, restarts
    start_phase(Q_ONE[31:0], Q_ONE[31:0], 32'hFFFF_FFFF);
    push_item(OP_OFFSET, 32'd0, 1'b1, '1, '1, 32'd0);
    push_item(OP_SAMPLE, 32'd0, 1'b0, '1, '1, '1);        // ms wraps, reading ignored
    push_item(OP_SAMPLE, 32'd5, 1'b1, 64'd0, 64'd0, '0);   // zero starts
    push_item(OP_SAMPLE, 32'd10, 1'b1, 64'd1000, 64'd1000, '0);
    push_item(OP_SAMPLE, 32'd20, 1'b1, 64'd2000, 64'd2000, '0);   // exactly 1.0
    push_item(OP_SAMPLE, 32'd30, 1'b1, 64'd2950, 64'd3000, '0);   // 0.975
    push_item(OP_SAMPLE, 32'd40, 1'b1, 64'd3100, 64'd4000, '0);   // 0.7, too low
    push_item(OP_SAMPLE, 32'd45, 1'b1, 64'd4060, 64'd4000, '0);   // 1.02
    push_item(OP_SAMPLE, 32'd50, 1'b1, 64'd20000, 64'd21000, '0); // 0.95 truncates low
    push_item(OP_SAMPLE, 32'd60, 1'b1, 64'd22000, 64'd21000, '0); // exactly 1.05
    push_item(OP_SAMPLE, 32'd70, 1'b1, 64'd22001, 64'd21000, '0); // just above 1.05
    push_item(OP_SAMPLE, 32'd75, 1'b1, 64'd22500, 64'd21500, '0);
    push_item(OP_SAMPLE, 32'd78, 1'b1, 64'd23000, 64'd1000, '0);  // no counter delta
    push_item(OP_SAMPLE, 32'd80, 1'b1, 64'd41000, 64'd21000, '0); // ratio of 2.0
    push_item(OP_SAMPLE, 32'd90, 1'b1, 64'd500, 64'd777, '0);     // clock backwards
    push_item(OP_SAMPLE, 32'd100, 1'b1, 64'd500, 64'd2000, '0);   // no clock delta
    push_item(OP_SAMPLE, 32'd110, 1'b1, 64'd1530, 64'd1777, '0);
    push_item(OP_SAMPLE, 32'd120, 1'b1, 64'd2000, 64'd100, '0);   // counter delta wraps
    push_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, '1, '1, '0);
    push_item(OP_OFFSET, 32'd0, 1'b0, '0, '0, 32'hFFFF_FFFF);
    push_item(OP_SAMPLE, 32'd0, 1'b0, '0, '0, '0);
    push_item(OP_SAMPLE, 32'h8000_0000, 1'b0, '0, '0, '0);

    // Random phases over several rate settings, extremes included
    gen_ms       = 32'h8000_0000;
    gen_last_clk = '1;
    sess_clk     = gen_last_clk >> 1;
    sess_cnt     = {$urandom, $urandom};
    sess_run     = '0;
    sess_rate    = 64'd1000;
    adj_set  = '{Q_ONE[31:0], 32'hFFFF_FFFF, 32'd0,
                 Q_ONE[31:0] + $urandom_range(0, 1 << 27) - (1 << 26),
                 $urandom, $urandom_range(0, 1 << 27) + 32'h3C00_0000};
    bias_set = '{Q_ONE[31:0], 32'hFFFF_FFFF, $urandom,
                 Q_ONE[31:0] + $urandom_range(0, 1 << 27) - (1 << 26),
                 $urandom, 32'd0};
    for (int ph = 0; ph < 6; ph++) begin
      start_phase(adj_set[ph], bias_set[ph], (ph % 2 == 0) ? 32'd0 : $urandom);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        pending_items.push_back(next_random_item());
        n_pushed++;
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (expected_times.size() != 0) begin
      n_errors += expected_times.size();
      $display("%0t: %0d expected results never arrived", $time, expected_times.size());
    end
    $display("Ran %0d items (%0d offsets) over %0d register writes; %0d results checked.",
             n_sent, n_offsets, n_writes, n_checked);
    $display("Drift ratios taken: %0d, clock restarts: %0d, mismatches: %0d.",
             n_ratios, n_restarts, n_errors);
    if (n_errors == 0) begin
      $display("drift_compensated_clock_top regression: pass");
    end else begin
      $display("drift_compensated_clock_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_500_000;
    $display("drift_compensated_clock_top regression: fail");
    $finish;
  end

endmodule
